/* design/console_bus_address_decoder_unit_defines.svh */
// ----------------------------------------------------------------------------
// Console bus address decoder: assertion macros
// Shared property forms for the checker; clk and rst name the sampling clock
// and the synchronous reset of the module that uses them.
// ----------------------------------------------------------------------------
`ifndef CONSOLE_BUS_ADDRESS_DECODER_UNIT_DEFINES_SVH
`define CONSOLE_BUS_ADDRESS_DECODER_UNIT_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define CBAD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("cbad: same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define CBAD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("cbad: next-cycle check failed");

`endif

/* design/cbad_pkg.sv */
// ----------------------------------------------------------------------------
// Console bus address decoder package
// Target and status codes, memory map constants and the word types that pass
// between the decoder modules.
// ----------------------------------------------------------------------------
package cbad_pkg;

  // Target codes
  localparam logic [4:0] T_NONE     = 5'd0;
  localparam logic [4:0] T_RAM      = 5'd1;
  localparam logic [4:0] T_EXP      = 5'd2;
  localparam logic [4:0] T_SCRATCH  = 5'd3;
  localparam logic [4:0] T_BIOS     = 5'd4;
  localparam logic [4:0] T_MEMCTRL  = 5'd5;
  localparam logic [4:0] T_PAD      = 5'd6;
  localparam logic [4:0] T_SERIAL   = 5'd7;
  localparam logic [4:0] T_IRQ      = 5'd8;
  localparam logic [4:0] T_DMA      = 5'd9;
  localparam logic [4:0] T_TIMER0   = 5'd10;
  localparam logic [4:0] T_TIMER1   = 5'd11;
  localparam logic [4:0] T_TIMER2   = 5'd12;
  localparam logic [4:0] T_CDROM    = 5'd13;
  localparam logic [4:0] T_GPU      = 5'd14;
  localparam logic [4:0] T_MDEC     = 5'd15;
  localparam logic [4:0] T_SPU      = 5'd16;
  localparam logic [4:0] T_EXP2     = 5'd17;
  localparam logic [4:0] T_CACHECTL = 5'd18;

  // Status codes
  localparam logic [2:0] S_OK          = 3'd0;
  localparam logic [2:0] S_IGNORED     = 3'd1;
  localparam logic [2:0] S_GPU_WIDTH   = 3'd2;
  localparam logic [2:0] S_UNMAPPED_IO = 3'd3;
  localparam logic [2:0] S_UNMAPPED    = 3'd4;
  localparam logic [2:0] S_CACHECTL    = 3'd5;
  localparam logic [2:0] S_FIXED       = 3'd6;

  // Access kind and width codes
  localparam logic       KIND_WRITE = 1'b1;
  localparam logic [1:0] W_BYTE     = 2'd0;
  localparam logic [1:0] W_HALF     = 2'd1;

  // Memory map on the 29-bit physical address
  localparam int unsigned EXPANSION_BYTES = 524288;
  localparam logic [28:0] RAM_END      = 29'h0080_0000;
  localparam logic [28:0] EXP_BASE     = 29'h1f00_0000;
  localparam logic [28:0] SCRATCH_BASE = 29'h1f80_0000;
  localparam logic [28:0] SCRATCH_END  = 29'h1f80_0400;
  localparam logic [28:0] BIOS_BASE    = 29'h1fc0_0000;
  localparam logic [28:0] BIOS_END     = 29'h1fc8_0000;
  localparam logic [28:0] IO_BASE      = 29'h1f80_1000;
  localparam logic [28:0] IO_LAST      = 29'h1f80_3000;
  localparam logic [20:0] RAM_MASK     = 21'h1f_ffff;

  // Cache-control port, word address of the original 32-bit address
  localparam logic [29:0] CACHECTL_WORD = 30'h3fff_804c;

  // Serial status read: I/O word at offset 0x54, serial block base 0x50
  localparam logic [11:0] SERIAL_STAT_WORD = 12'h015;
  localparam logic [13:0] SERIAL_BASE      = 14'h0050;
  localparam logic [31:0] SERIAL_STAT_VAL  = 32'h0000_0005;

  // I/O peripheral spans, half-open [lo, hi) on the 14-bit I/O offset
  localparam int IO_SPANS = 14;

  typedef struct packed {
    logic [13:0] lo;
    logic [13:0] hi;
    logic [4:0]  target;
  } io_span_t;

  localparam io_span_t IO_MAP [IO_SPANS] = '{
    '{14'h0000, 14'h0024, T_MEMCTRL},
    '{14'h0040, 14'h0050, T_PAD},
    '{14'h0050, 14'h0060, T_SERIAL},
    '{14'h0060, 14'h0064, T_MEMCTRL},
    '{14'h0070, 14'h0078, T_IRQ},
    '{14'h0080, 14'h0100, T_DMA},
    '{14'h0100, 14'h0110, T_TIMER0},
    '{14'h0110, 14'h0120, T_TIMER1},
    '{14'h0120, 14'h0130, T_TIMER2},
    '{14'h0800, 14'h0804, T_CDROM},
    '{14'h0810, 14'h0818, T_GPU},
    '{14'h0820, 14'h0828, T_MDEC},
    '{14'h0c00, 14'h1000, T_SPU},
    '{14'h1000, 14'h1043, T_EXP2}
  };

  typedef struct packed {
    logic        kind;
    logic [31:0] bus_address;
    logic [1:0]  access_width;
    logic [31:0] write_value;
  } access_t;

  typedef struct packed {
    logic [4:0]  target;
    logic [20:0] region_offset;
    logic        byte_serial;
    logic [2:0]  status;
    logic [31:0] bus_data;
  } result_t;

  typedef struct packed {
    logic        hit;
    logic [4:0]  target;
    logic [13:0] offset;
  } io_hit_t;

endpackage

/* design/cbad_intf.sv */
// ----------------------------------------------------------------------------
// Console bus address decoder channels
// Valid/ready channels for bus accesses, decode results and the config word.
// ----------------------------------------------------------------------------
interface cbad_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] bus_address;
  logic [1:0]  access_width;
  logic [31:0] write_value;

  modport source (output valid, kind, bus_address, access_width, write_value,
                  input ready);
  modport sink   (input valid, kind, bus_address, access_width, write_value,
                  output ready);
endinterface

interface cbad_rsp_if;
  logic        valid;
  logic        ready;
  logic [4:0]  target;
  logic [20:0] region_offset;
  logic        byte_serial;
  logic [2:0]  status;
  logic [31:0] bus_data;

  modport source (output valid, target, region_offset, byte_serial, status, bus_data,
                  input ready);
  modport sink   (input valid, target, region_offset, byte_serial, status, bus_data,
                  output ready);
endinterface

interface cbad_cfg_if;
  logic valid;
  logic ready;
  logic isolate_cache;

  modport source (output valid, isolate_cache, input ready);
  modport sink   (input valid, isolate_cache, output ready);
endinterface

/* design/console_bus_address_decoder_unit.sv */
// ----------------------------------------------------------------------------
// Console bus address decoder unit
// Decodes one bus access a cycle when not stalled: target, offset and status.
// ----------------------------------------------------------------------------
// Each accepted access gives exactly one result: the access is captured in
// an input register, decoded by one pass of compare logic and held in the
// result register until taken. One access is accepted every cycle while the
// result side keeps up; the result register and the input register stall
// together only when both are full. The isolate_cache word may be written
// at any time and affects RAM writes decoded after it lands.
module console_bus_address_decoder_unit (
  input  logic       clk,
  input  logic       rst,
  cbad_cfg_if.sink   cfg,
  cbad_req_if.sink   req,
  cbad_rsp_if.source rsp
);

  logic              isolate_cache;
  logic              s1_valid;
  cbad_pkg::access_t s1_acc;
  logic              rsp_valid;
  cbad_pkg::result_t rsp_res;
  cbad_pkg::result_t dec_res;
  logic              s2_take;
  logic              s1_take;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      isolate_cache <= 1'b0;
    end else if (cfg.valid) begin
      isolate_cache <= cfg.isolate_cache;
    end
  end

  // Advance each stage when its downstream slot is free or draining.
  assign s2_take   = !rsp_valid || rsp.ready;
  assign s1_take   = !s1_valid || s2_take;
  assign req.ready = s1_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_take) begin
      s1_valid <= req.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_take && req.valid) begin
      s1_acc <= '{kind:         req.kind,
                  bus_address:  req.bus_address,
                  access_width: req.access_width,
                  write_value:  req.write_value};
    end
  end

  cbad_decode u_decode (
    .acc           (s1_acc),
    .isolate_cache (isolate_cache),
    .res           (dec_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (s2_take) begin
      rsp_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_take && s1_valid) begin
      rsp_res <= dec_res;
    end
  end

  assign rsp.valid         = rsp_valid;
  assign rsp.target        = rsp_res.target;
  assign rsp.region_offset = rsp_res.region_offset;
  assign rsp.byte_serial   = rsp_res.byte_serial;
  assign rsp.status        = rsp_res.status;
  assign rsp.bus_data      = rsp_res.bus_data;

endmodule

/* design/cbad_io_map.sv */
// ----------------------------------------------------------------------------
// Console bus address decoder: I/O peripheral lookup
// Matches an I/O window offset against the peripheral spans in parallel and
// returns the hit target and the offset within it.
// ----------------------------------------------------------------------------
module cbad_io_map (
  input  logic [13:0]      io,
  output cbad_pkg::io_hit_t hit
);

  logic [cbad_pkg::IO_SPANS-1:0] match;

  always_comb begin
    for (int i = 0; i < cbad_pkg::IO_SPANS; i++) begin
      match[i] = (io >= cbad_pkg::IO_MAP[i].lo) && (io < cbad_pkg::IO_MAP[i].hi);
    end
  end

  // Spans do not overlap, so at most one match is set.
  always_comb begin
    hit = '0;
    for (int i = 0; i < cbad_pkg::IO_SPANS; i++) begin
      if (match[i]) begin
        hit.hit    = 1'b1;
        hit.target = cbad_pkg::IO_MAP[i].target;
        hit.offset = io - cbad_pkg::IO_MAP[i].lo;
      end
    end
  end

endmodule

/* design/cbad_decode.sv */
// ----------------------------------------------------------------------------
// Console bus address decoder: region decode
// Masks and aligns the address, then picks the target region, offset, status
// and bus data for one access.
// ----------------------------------------------------------------------------
module cbad_decode (
  input  cbad_pkg::access_t acc,
  input  logic              isolate_cache,
  output cbad_pkg::result_t res
);

  logic [28:0] low_clear;
  logic [31:0] data_mask;
  logic [28:0] addr;
  logic [31:0] data;
  logic        wr;
  logic [28:0] exp_diff;
  logic [28:0] rel;
  logic [13:0] io;
  logic        in_io;
  cbad_pkg::io_hit_t io_hit;

  always_comb begin
    case (acc.access_width)
      cbad_pkg::W_BYTE: begin
        low_clear = '1;
        data_mask = 32'h0000_00ff;
      end
      cbad_pkg::W_HALF: begin
        low_clear = ~29'd1;
        data_mask = 32'h0000_ffff;
      end
      default: begin
        low_clear = ~29'd3;
        data_mask = 32'hffff_ffff;
      end
    endcase
  end

  assign wr       = (acc.kind == cbad_pkg::KIND_WRITE);
  assign addr     = acc.bus_address[28:0] & low_clear;
  assign data     = wr ? (acc.write_value & data_mask) : 32'd0;
  assign exp_diff = addr - cbad_pkg::EXP_BASE;
  assign in_io    = (addr >= cbad_pkg::IO_BASE) && (addr <= cbad_pkg::IO_LAST);
  assign rel      = addr - cbad_pkg::IO_BASE;
  assign io       = rel[13:0];

  cbad_io_map u_io_map (
    .io  (io),
    .hit (io_hit)
  );

  always_comb begin
    res          = '0;
    res.bus_data = data;
    if (addr < cbad_pkg::RAM_END) begin
      res.target        = cbad_pkg::T_RAM;
      res.region_offset = addr[20:0] & cbad_pkg::RAM_MASK;
      res.status        = (wr && isolate_cache) ? cbad_pkg::S_IGNORED : cbad_pkg::S_OK;
    end else if (addr >= cbad_pkg::EXP_BASE &&
                 exp_diff < 29'(cbad_pkg::EXPANSION_BYTES)) begin
      res.target        = cbad_pkg::T_EXP;
      res.region_offset = exp_diff[20:0];
    end else if (addr >= cbad_pkg::SCRATCH_BASE && addr < cbad_pkg::SCRATCH_END) begin
      res.target        = cbad_pkg::T_SCRATCH;
      res.region_offset = {11'd0, addr[9:0]};
    end else if (!wr && addr >= cbad_pkg::BIOS_BASE && addr < cbad_pkg::BIOS_END) begin
      res.target        = cbad_pkg::T_BIOS;
      res.region_offset = {2'd0, addr[18:0]};
    end else if (in_io) begin
      if (!wr && io[13:2] == cbad_pkg::SERIAL_STAT_WORD) begin
        // Only the first byte of the status word reads nonzero.
        res.target        = cbad_pkg::T_SERIAL;
        res.region_offset = 21'(io - cbad_pkg::SERIAL_BASE);
        res.status        = cbad_pkg::S_FIXED;
        res.bus_data      = (io[1:0] == 2'd0) ? cbad_pkg::SERIAL_STAT_VAL : 32'd0;
      end else if (io_hit.hit) begin
        res.target        = io_hit.target;
        res.region_offset = 21'(io_hit.offset);
        if (io_hit.target == cbad_pkg::T_GPU) begin
          res.status = (acc.access_width[1]) ? cbad_pkg::S_OK : cbad_pkg::S_GPU_WIDTH;
        end else begin
          res.byte_serial = 1'b1;
        end
      end else begin
        res.status = cbad_pkg::S_UNMAPPED_IO;
      end
    end else if (acc.bus_address[31:2] == cbad_pkg::CACHECTL_WORD) begin
      res.target        = cbad_pkg::T_CACHECTL;
      res.region_offset = {19'd0, addr[1:0]};
      res.status        = cbad_pkg::S_CACHECTL;
    end else begin
      res.status = cbad_pkg::S_UNMAPPED;
    end
  end

endmodule

/* design/cbad_checker.sv */
// ----------------------------------------------------------------------------
// Console bus address decoder: port checker
// Watches the top-level ports for result holding, code consistency and
// throughput when the result side is empty.
// ----------------------------------------------------------------------------
`include "console_bus_address_decoder_unit_defines.svh"

module cbad_checker (
  input logic        clk,
  input logic        rst,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [4:0]  rsp_target,
  input logic [20:0] rsp_region_offset,
  input logic        rsp_byte_serial,
  input logic [2:0]  rsp_status,
  input logic [31:0] rsp_bus_data
);

  logic [61:0] rsp_word;

  assign rsp_word = {rsp_target, rsp_region_offset, rsp_byte_serial, rsp_status, rsp_bus_data};

  // A stalled result holds.
  `CBAD_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_word))

  // With the result slot empty the input side never stalls.
  `CBAD_ASSERT_NOW(a_no_stall_when_empty, !rsp_valid, req_ready)

  // Split accesses only go to ok, non-GPU peripherals.
  `CBAD_ASSERT_NOW(a_byte_serial_codes, rsp_valid && rsp_byte_serial, rsp_status == cbad_pkg::S_OK && rsp_target >= cbad_pkg::T_MEMCTRL && rsp_target <= cbad_pkg::T_EXP2 && rsp_target != cbad_pkg::T_GPU)

  // No target means an unmapped status with zero offset.
  `CBAD_ASSERT_NOW(a_none_unmapped, rsp_valid && rsp_target == cbad_pkg::T_NONE, rsp_region_offset == 21'd0 && (rsp_status == cbad_pkg::S_UNMAPPED || rsp_status == cbad_pkg::S_UNMAPPED_IO))

  // The fixed read is the serial status byte.
  `CBAD_ASSERT_NOW(a_fixed_serial, rsp_valid && rsp_status == cbad_pkg::S_FIXED, rsp_target == cbad_pkg::T_SERIAL && rsp_bus_data[31:3] == 29'd0)

endmodule

bind console_bus_address_decoder_unit cbad_checker u_cbad_checker (
  .clk               (clk),
  .rst               (rst),
  .req_ready         (req.ready),
  .rsp_valid         (rsp.valid),
  .rsp_ready         (rsp.ready),
  .rsp_target        (rsp.target),
  .rsp_region_offset (rsp.region_offset),
  .rsp_byte_serial   (rsp.byte_serial),
  .rsp_status        (rsp.status),
  .rsp_bus_data      (rsp.bus_data)
);
